// ----- rtl/rtac_pkg.sv -----
`default_nettype none

package rtac_pkg;

    // Event selector carried on s_tuser
    typedef enum logic [3:0] {
        OP_FETCH        = 4'd0,
        OP_RETN_TICK    = 4'd1,
        OP_RETN_DONE    = 4'd2,
        OP_RETN_NOW     = 4'd3,
        OP_NMI_BUTTON   = 4'd4,
        OP_CTRL_WRITE   = 4'd5,
        OP_CTRL_READ    = 4'd6,
        OP_CLEAR_MAPRAM = 4'd7,
        OP_SET_ENABLES  = 4'd8,
        OP_MAP_QUERY    = 4'd9
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_RST_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_RST_MAIN     = 3'd1;
    localparam logic [2:0] CFG_RST_INSTANT  = 3'd2;
    localparam logic [2:0] CFG_SPECIAL      = 3'd3;

    localparam logic [7:0] RST_ENABLE_RESET  = 8'h83;
    localparam logic [7:0] RST_MAIN_RESET    = 8'h01;
    localparam logic [7:0] RST_INSTANT_RESET = 8'h00;
    localparam logic [7:0] SPECIAL_RESET     = 8'hCD;

    // Special entry enable bits
    localparam int SP_NMI_DELAYED = 0;
    localparam int SP_NMI_INSTANT = 1;
    localparam int SP_TAPE_0      = 2;
    localparam int SP_TAPE_1      = 3;
    localparam int SP_TAPE_2      = 4;
    localparam int SP_TAPE_3      = 5;
    localparam int SP_UNMAP       = 6;
    localparam int SP_WILDCARD    = 7;

    localparam logic [15:0] NMI_VECTOR   = 16'h0066;
    localparam logic [15:0] TAPE_ADDR_0  = 16'h04C6;
    localparam logic [15:0] TAPE_ADDR_1  = 16'h0562;
    localparam logic [15:0] TAPE_ADDR_2  = 16'h04D7;
    localparam logic [15:0] TAPE_ADDR_3  = 16'h056A;
    localparam logic [7:0]  WILDCARD_HI  = 8'h3D;
    localparam logic [15:0] UNMAP_LOW    = 16'h1FF8;
    localparam logic [15:0] UNMAP_HIGH   = 16'h1FFF;
    localparam logic [15:0] SLOT1_BASE   = 16'h2000;
    localparam logic [15:0] SLOT2_BASE   = 16'h4000;
    localparam logic [3:0]  LOWER_PAGE   = 4'd3;

    typedef struct packed {
        logic [7:0] rst_enable;
        logic [7:0] rst_main;
        logic [7:0] rst_instant;
        logic [7:0] special;
    } trap_cfg_t;

    typedef struct packed {
        logic inst;
        logic del;
        logic off;
    } trap_hit_t;

endpackage

`default_nettype wire

// ----- rtl/rtac_trap_decode.sv -----
`default_nettype none

module rtac_trap_decode (
    input  wire logic [15:0]        pc,
    input  wire logic               main_ok,
    input  wire logic               rom3_ok,
    input  wire logic               nmi_latch,
    input  wire rtac_pkg::trap_cfg_t cfg,
    output rtac_pkg::trap_hit_t     hit
);
    import rtac_pkg::*;

    logic [7:0] rst_match;
    logic       rst_hit;
    logic       rst_gate;
    logic       rst_inst;
    logic       sp_inst;
    logic       sp_del;
    logic       sp_off;
    logic       tape_hit;

    // Vectors sit at distinct addresses, so at most one can match
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rst_match[i] = cfg.rst_enable[i] && (pc == 16'(i * 8));
        end
    end

    assign rst_hit  = |rst_match;
    assign rst_gate = (|(rst_match & cfg.rst_main)) ? main_ok : rom3_ok;
    assign rst_inst = |(rst_match & cfg.rst_instant);

    assign tape_hit = rom3_ok && (
        (cfg.special[SP_TAPE_0] && pc == TAPE_ADDR_0) ||
        (cfg.special[SP_TAPE_1] && pc == TAPE_ADDR_1) ||
        (cfg.special[SP_TAPE_2] && pc == TAPE_ADDR_2) ||
        (cfg.special[SP_TAPE_3] && pc == TAPE_ADDR_3));

    always_comb begin
        sp_inst = 1'b0;
        sp_del  = tape_hit;
        if (pc == NMI_VECTOR && nmi_latch && main_ok) begin
            sp_inst = cfg.special[SP_NMI_INSTANT];
            sp_del  = tape_hit || cfg.special[SP_NMI_DELAYED];
        end
        if (cfg.special[SP_WILDCARD] && pc[15:8] == WILDCARD_HI && rom3_ok) begin
            sp_inst = 1'b1;
        end
        sp_off = cfg.special[SP_UNMAP] && pc >= UNMAP_LOW && pc <= UNMAP_HIGH && main_ok;
    end

    // A vector hit masks the special entries
    always_comb begin
        if (rst_hit) begin
            hit.inst = rst_gate && rst_inst;
            hit.del  = rst_gate && !rst_inst;
            hit.off  = 1'b0;
        end else begin
            hit.inst = sp_inst;
            hit.del  = sp_del;
            hit.off  = sp_off;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rom_trap_automap_controller_unit.sv -----
`default_nettype none

// Channel  | Handshake        | Payload (low bit up)
// ---------+------------------+----------------------------------------------
// s_       | s_tvalid/tready  | tuser: op; tdata: address, data, override_main,
//          |                  |   override_rom3, rom3_selected, layer2_read_map,
//          |                  |   retn_flag, port_enable_value, automap_enable_value
// m_       | m_tvalid/tready  | tdata: read_data, automap, hold_flag, nmi_latched,
//          |                  |   overlay_active, ram_mapped, read_only, ram_page,
//          |                  |   from_rom
// cfg_     | cfg_wr_en        | cfg_index selects register, cfg_wdata value
//
// One transaction per cycle sustained while m_tready stays high. A result is
// presented after its input transaction passes the input register, then the result register.
// The state update and all address compares sit between those two registers.
// Reset (aresetn low, synchronous) empties both stages and loads state and
// configuration defaults. A stalled result holds in place; the input register
// still takes one transaction while empty, then s_tready drops until it drains.
module rom_trap_automap_controller_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [3:0]  s_tuser,   // op
    input  wire logic [31:0] s_tdata,   // address[15:0], data[23:16], override_main[24],
                                        // override_rom3[25], rom3_selected[26],
                                        // layer2_read_map[27], retn_flag[28],
                                        // port_enable_value[29], automap_enable_value[30]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // read_data[7:0], automap[8], hold_flag[9],
                                        // nmi_latched[10], overlay_active[11],
                                        // ram_mapped[12], read_only[13],
                                        // ram_page[17:14], from_rom[18]

    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import rtac_pkg::*;

    // Configuration registers
    trap_cfg_t   cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rst_enable  <= RST_ENABLE_RESET;
            cfg_reg.rst_main    <= RST_MAIN_RESET;
            cfg_reg.rst_instant <= RST_INSTANT_RESET;
            cfg_reg.special     <= SPECIAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RST_ENABLE:  cfg_reg.rst_enable  <= cfg_wdata;
                CFG_RST_MAIN:    cfg_reg.rst_main    <= cfg_wdata;
                CFG_RST_INSTANT: cfg_reg.rst_instant <= cfg_wdata;
                CFG_SPECIAL:     cfg_reg.special     <= cfg_wdata;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Input register stage
    logic        in_valid_reg;
    logic [3:0]  in_op_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        advance;

    // Process the held item when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Unpack the held item
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        ov_main, ov_rom3, rom3_on, l2_map, rseen, pe_val, ae_val;

    assign addr     = in_data_reg[15:0];
    assign wdata    = in_data_reg[23:16];
    assign ov_main  = in_data_reg[24];
    assign ov_rom3  = in_data_reg[25];
    assign rom3_on  = in_data_reg[26];
    assign l2_map   = in_data_reg[27];
    assign rseen    = in_data_reg[28];
    assign pe_val   = in_data_reg[29];
    assign ae_val   = in_data_reg[30];

    // Block state
    logic       conmem_reg,   conmem_next;
    logic       mapram_reg,   mapram_next;
    logic [3:0] bank_reg,     bank_next;
    logic       automap_reg,  automap_next;
    logic       hold_reg,     hold_next;
    logic       held_reg,     held_next;
    logic       nmi_reg,      nmi_next;
    logic       retn_reg,     retn_next;
    logic       port_en_reg,  port_en_next;
    logic       auto_en_reg,  auto_en_next;

    logic       enabled;
    logic       rom3_ok;
    logic       nmi_eff;
    trap_hit_t  hit;

    assign enabled = port_en_reg && auto_en_reg;
    assign rom3_ok = ov_main && ov_rom3 && !l2_map && rom3_on;
    // Hold latch set after the transfer masks the NMI button latch
    assign nmi_eff = nmi_reg && !hold_reg;

    rtac_trap_decode u_decode (
        .pc        (addr),
        .main_ok   (ov_main),
        .rom3_ok   (rom3_ok),
        .nmi_latch (nmi_eff),
        .cfg       (cfg_reg),
        .hit       (hit)
    );

    // Query decode
    logic q_low, q_slot1;
    assign q_low   = addr < SLOT1_BASE;
    assign q_slot1 = !q_low && addr < SLOT2_BASE;

    logic [7:0] rd_val;
    logic       rm_val, ro_val, fr_val;
    logic [3:0] pg_val;

    always_comb begin
        conmem_next  = conmem_reg;
        mapram_next  = mapram_reg;
        bank_next    = bank_reg;
        automap_next = automap_reg;
        hold_next    = hold_reg;
        held_next    = held_reg;
        nmi_next     = nmi_reg;
        retn_next    = retn_reg;
        port_en_next = port_en_reg;
        auto_en_next = auto_en_reg;
        rd_val = '0;
        rm_val = 1'b0;
        ro_val = 1'b0;
        pg_val = '0;
        fr_val = 1'b0;

        case (op_t'(in_op_reg))
            OP_FETCH: begin
                if (enabled) begin
                    held_next    = hold_reg;
                    nmi_next     = nmi_eff;
                    hold_next    = hit.inst || hit.del || (hold_reg && !hit.off);
                    automap_next = hold_reg || hit.inst;
                end
            end
            OP_RETN_TICK: begin
                if (retn_reg) begin
                    automap_next = 1'b0;
                    hold_next    = 1'b0;
                    held_next    = 1'b0;
                    nmi_next     = 1'b0;
                    retn_next    = 1'b0;
                end
                if (rseen) begin
                    retn_next = 1'b1;
                end
            end
            OP_RETN_DONE: begin
                if (retn_reg) begin
                    automap_next = 1'b0;
                    hold_next    = 1'b0;
                    held_next    = 1'b0;
                    nmi_next     = 1'b0;
                    retn_next    = 1'b0;
                end
            end
            OP_RETN_NOW: begin
                automap_next = 1'b0;
                hold_next    = 1'b0;
                held_next    = 1'b0;
                nmi_next     = 1'b0;
                retn_next    = 1'b0;
            end
            OP_NMI_BUTTON: begin
                nmi_next = 1'b1;
            end
            OP_CTRL_WRITE: begin
                conmem_next = wdata[7];
                mapram_next = mapram_reg || wdata[6];   // sticky until cleared
                bank_next   = wdata[3:0];
            end
            OP_CTRL_READ: begin
                rd_val = {conmem_reg, mapram_reg, 2'b00, bank_reg};
            end
            OP_CLEAR_MAPRAM: begin
                mapram_next = 1'b0;
            end
            OP_SET_ENABLES: begin
                port_en_next = pe_val;
                auto_en_next = ae_val;
                // Falling edge of the combined enable clears the pipeline
                if (enabled && !(pe_val && ae_val)) begin
                    automap_next = 1'b0;
                    hold_next    = 1'b0;
                    held_next    = 1'b0;
                    nmi_next     = 1'b0;
                    retn_next    = 1'b0;
                end
            end
            OP_MAP_QUERY: begin
                rm_val = (conmem_reg || automap_reg) &&
                         ((q_low && mapram_reg) || q_slot1);
                ro_val = q_low || (q_slot1 && mapram_reg && bank_reg == LOWER_PAGE);
                pg_val = q_low ? LOWER_PAGE : bank_reg;
                fr_val = q_low && !mapram_reg;
            end
            default: begin
                // unused codes only report status
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conmem_reg  <= 1'b0;
            mapram_reg  <= 1'b0;
            bank_reg    <= '0;
            automap_reg <= 1'b0;
            hold_reg    <= 1'b0;
            held_reg    <= 1'b0;
            nmi_reg     <= 1'b0;
            retn_reg    <= 1'b0;
            port_en_reg <= 1'b1;
            auto_en_reg <= 1'b0;
        end else if (advance) begin
            conmem_reg  <= conmem_next;
            mapram_reg  <= mapram_next;
            bank_reg    <= bank_next;
            automap_reg <= automap_next;
            hold_reg    <= hold_next;
            held_reg    <= held_next;
            nmi_reg     <= nmi_next;
            retn_reg    <= retn_next;
            port_en_reg <= port_en_next;
            auto_en_reg <= auto_en_next;
        end
    end

    // Result register: hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'b00000, fr_val, pg_val, ro_val, rm_val,
                             conmem_next || automap_next, nmi_next,
                             hold_next, automap_next, rd_val};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The held latch is only ever set together with automap
    a_held_implies_automap: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> automap_reg)
        else $error("held latch set without automap");

    // An immediate RETN clear empties the whole latch pipeline
    a_retn_now_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_RETN_NOW) |=>
            (!automap_reg && !hold_reg && !held_reg && !nmi_reg && !retn_reg))
        else $error("RETN clear left pipeline state");

    // A fetch while disabled leaves the latches untouched
    a_disabled_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_FETCH && !enabled) |=>
            ($stable(hold_reg) && $stable(automap_reg) && $stable(held_reg)))
        else $error("fetch changed state while disabled");

    // An empty input stage always takes a transaction
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

endmodule

`default_nettype wire
